@@ hw/rtl/taqe_pkg.sv @@
// ----------------------------------------------------------------------------
// taqe_pkg - shared types and constants of the tree ancestor query engine
// Field widths, operation codes and the packed entry/exit time word.
// ----------------------------------------------------------------------------
`default_nettype none

package taqe_pkg;

    localparam int NODE_W        = 10;   // node number field
    localparam int TIME_W        = 11;   // DFS entry / exit time
    localparam int LVL_FW        = 4;    // level field of a write word
    localparam int DIST_W        = 10;   // lift distance field
    localparam int CFG_W         = 4;    // max_level register
    localparam int MAX_LEVEL_RST = 10;   // max_level after reset

    typedef enum logic [1:0] {
        OP_WR_ANC  = 2'd0,
        OP_WR_TIME = 2'd1,
        OP_LCA     = 2'd2,
        OP_LIFT    = 2'd3
    } t_op;

    typedef struct packed {
        logic [TIME_W-1:0] t_entry;
        logic [TIME_W-1:0] t_exit;
    } t_times;

endpackage

`default_nettype wire

@@ hw/rtl/tree_ancestor_query_engine_unit.sv @@
// ----------------------------------------------------------------------------
// tree_ancestor_query_engine_unit - LCA / k-th ancestor by binary lifting
// Holds the lifting table and DFS times; answers common ancestor and
// ancestor-at-distance queries with one shared interval comparator.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake                      | payload
//  ----------+-----------+--------------------------------+----------------------------
//  command   | in        | i_start, o_busy (take: !busy)  | i_op, i_node_a, i_node_b,
//            |           |                                | i_level, i_ancestor_node,
//            |           |                                | i_entry_time, i_exit_time,
//            |           |                                | i_distance
//  result    | out       | o_done strobe, one cycle       | o_result_node
//  config    | in        | i_cfg_valid, o_cfg_ready (=1)  | i_cfg_data (max_level)
//
//  Table writes finish in the accept cycle, busy never rises.
//  Common ancestor: read both nodes' times and make the two interval tests
//  (TA, TB, TC), then per level an ancestor RAM read (W) and a time RAM
//  read + compare (CMP), top level down to level 0, then a final parent
//  read (FIN). When one node covers the other the strobe comes from TB or
//  TC. Each level loops ancestor RAM -> time RAM -> comparator.
//  Ancestor at distance: a level with a clear distance bit passes through
//  LR only, a set bit through LR and then LQ, from the top level down to 0.
//  Reset: synchronous, active low; max_level returns to 10. Table contents
//  are not cleared and must be written before use.
//  The result strobe is high for one cycle; o_result_node then holds until
//  the next result. The receiver cannot stall it.
// ----------------------------------------------------------------------------
`default_nettype none

module tree_ancestor_query_engine_unit
    import taqe_pkg::*;
#(
    parameter int NODES  = 1024,
    parameter int LEVELS = 11
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // command word
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire logic [1:0]        i_op,
    input  wire logic [NODE_W-1:0] i_node_a,
    input  wire logic [NODE_W-1:0] i_node_b,
    input  wire logic [LVL_FW-1:0] i_level,
    input  wire logic [NODE_W-1:0] i_ancestor_node,
    input  wire logic [TIME_W-1:0] i_entry_time,
    input  wire logic [TIME_W-1:0] i_exit_time,
    input  wire logic [DIST_W-1:0] i_distance,
    // result word
    output logic                   o_done,
    output logic      [NODE_W-1:0] o_result_node,
    // config word
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CFG_W-1:0]  i_cfg_data
);

    localparam int NODE_AW   = $clog2(NODES);
    localparam int ANC_DEPTH = NODES * LEVELS;
    localparam int ANC_AW    = $clog2(ANC_DEPTH);
    localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int TIMES_W   = 2 * TIME_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TA,       // capture times of a, read times of b
        S_TB,       // test a covers b
        S_TC,       // test b covers a, start lifting
        S_W,        // capture lifted node w, read its times
        S_CMP,      // test w covers b, pick u, read next level
        S_FIN,      // parent of u is the answer
        S_LR,       // lift: check distance bit, read table
        S_LQ        // lift: take the ancestor
    } t_state;

    // nodes past the table read as zero
    function automatic logic node_ok(input logic [NODE_W-1:0] n);
        return 32'(n) < NODES;
    endfunction

    function automatic logic [ANC_AW-1:0] anc_base(input logic [NODE_W-1:0] n);
        return ANC_AW'(32'(n) * 32'(LEVELS));
    endfunction

    function automatic logic [ANC_AW-1:0] anc_addr(input logic [ANC_AW-1:0] base,
                                                   input logic [LVL_W-1:0]  lvl);
        return ANC_AW'(32'(base) + 32'(lvl));
    endfunction

    // ---- registers ---------------------------------------------------------
    t_state              r_state,     n_state;
    logic [CFG_W-1:0]    r_max_level;
    logic                r_done,      n_done;
    logic [NODE_W-1:0]   r_result,    n_result;
    logic [NODE_W-1:0]   r_a,         n_a;
    logic [NODE_W-1:0]   r_b,         n_b;
    logic [NODE_W-1:0]   r_u,         n_u;        // node being lifted
    logic [ANC_AW-1:0]   r_ubase,     n_ubase;    // u * LEVELS
    logic [NODE_W-1:0]   r_w,         n_w;        // candidate ancestor
    logic [ANC_AW-1:0]   r_wbase,     n_wbase;
    logic [LVL_W-1:0]    r_lvl,       n_lvl;      // current level
    logic [DIST_W-1:0]   r_dist,      n_dist;
    t_times              r_tu,        n_tu;       // times of a
    t_times              r_tv,        n_tv;       // times of b
    logic                r_ard_ok,    n_ard_ok;   // ancestor read in range
    logic                r_trd_ok,    n_trd_ok;   // time read in range

    // ---- memories ----------------------------------------------------------
    logic                anc_we;
    logic [ANC_AW-1:0]   anc_waddr, anc_raddr;
    logic [NODE_W-1:0]   anc_q;
    logic                tim_we;
    logic [NODE_AW-1:0]  tim_waddr, tim_raddr;
    logic [TIMES_W-1:0]  tim_wdata, tim_q;

    taqe_ram #(.WIDTH(NODE_W), .DEPTH(ANC_DEPTH)) u_anc_ram (
        .i_clk   (i_clk),
        .i_we    (anc_we),
        .i_waddr (anc_waddr),
        .i_wdata (i_ancestor_node),
        .i_raddr (anc_raddr),
        .o_rdata (anc_q)
    );

    taqe_ram #(.WIDTH(TIMES_W), .DEPTH(NODES)) u_tim_ram (
        .i_clk   (i_clk),
        .i_we    (tim_we),
        .i_waddr (tim_waddr),
        .i_wdata (tim_wdata),
        .i_raddr (tim_raddr),
        .o_rdata (tim_q)
    );

    // ---- shared comparator -------------------------------------------------
    t_times              cmp_anc, cmp_des;
    logic                cmp_cov;

    taqe_cmp u_cmp (
        .i_anc    (cmp_anc),
        .i_des    (cmp_des),
        .o_covers (cmp_cov)
    );

    // ---- helpers -----------------------------------------------------------
    logic [NODE_W-1:0]   anc_val;
    t_times              tim_val;
    logic [LVL_W-1:0]    top_lvl;
    logic [LVL_W-1:0]    next_lvl;
    logic [31:0]         dist_sh;
    logic                sel_w;

    assign anc_val  = r_ard_ok ? anc_q : '0;
    assign tim_val  = r_trd_ok ? t_times'(tim_q) : '0;
    // max_level saturates at the top of the table
    assign top_lvl  = (32'(r_max_level) > LEVELS - 1) ? LVL_W'(LEVELS - 1)
                                                       : LVL_W'(r_max_level);
    assign next_lvl = (r_lvl == '0) ? '0 : r_lvl - LVL_W'(1);
    assign dist_sh  = 32'(r_dist) >> r_lvl;   // bits above the field read zero
    assign sel_w    = !cmp_cov;

    assign tim_wdata = {i_entry_time, i_exit_time};
    assign anc_waddr = ANC_AW'(32'(i_node_a) * 32'(LEVELS) + 32'(i_level));
    assign tim_waddr = NODE_AW'(i_node_a);

    // ---- sequencer ---------------------------------------------------------
    always_comb begin
        n_state  = r_state;
        n_done   = 1'b0;
        n_result = r_result;
        n_a      = r_a;
        n_b      = r_b;
        n_u      = r_u;
        n_ubase  = r_ubase;
        n_w      = r_w;
        n_wbase  = r_wbase;
        n_lvl    = r_lvl;
        n_dist   = r_dist;
        n_tu     = r_tu;
        n_tv     = r_tv;
        n_ard_ok = r_ard_ok;
        n_trd_ok = r_trd_ok;
        anc_we   = 1'b0;
        tim_we   = 1'b0;
        anc_raddr = anc_addr(r_ubase, r_lvl);
        tim_raddr = NODE_AW'(r_b);
        cmp_anc  = r_tu;
        cmp_des  = tim_val;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_a     = i_node_a;
                    n_b     = i_node_b;
                    n_u     = i_node_a;
                    n_ubase = anc_base(i_node_a);
                    n_dist  = i_distance;
                    n_lvl   = top_lvl;
                    case (t_op'(i_op))
                        OP_WR_ANC: begin
                            anc_we = node_ok(i_node_a) && (32'(i_level) < LEVELS);
                        end
                        OP_WR_TIME: begin
                            tim_we = node_ok(i_node_a);
                        end
                        OP_LCA: begin
                            tim_raddr = NODE_AW'(i_node_a);
                            n_trd_ok  = node_ok(i_node_a);
                            n_state   = S_TA;
                        end
                        default: begin
                            n_state = S_LR;
                        end
                    endcase
                end
            end
            S_TA: begin
                n_tu      = tim_val;
                tim_raddr = NODE_AW'(r_b);
                n_trd_ok  = node_ok(r_b);
                n_state   = S_TB;
            end
            S_TB: begin
                n_tv    = tim_val;
                cmp_anc = r_tu;
                cmp_des = tim_val;
                if (cmp_cov) begin
                    n_result = r_a;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_TC;
                end
            end
            S_TC: begin
                cmp_anc = r_tv;
                cmp_des = r_tu;
                if (cmp_cov) begin
                    n_result = r_b;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    anc_raddr = anc_addr(r_ubase, r_lvl);
                    n_ard_ok  = node_ok(r_u);
                    n_state   = S_W;
                end
            end
            S_W: begin
                n_w       = anc_val;
                n_wbase   = anc_base(anc_val);
                tim_raddr = NODE_AW'(anc_val);
                n_trd_ok  = node_ok(anc_val);
                n_state   = S_CMP;
            end
            S_CMP: begin
                cmp_anc = tim_val;
                cmp_des = r_tv;
                // w not above b: climb to w
                if (sel_w) begin
                    n_u     = r_w;
                    n_ubase = r_wbase;
                end
                anc_raddr = anc_addr(sel_w ? r_wbase : r_ubase, next_lvl);
                n_ard_ok  = node_ok(sel_w ? r_w : r_u);
                if (r_lvl == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_lvl   = next_lvl;
                    n_state = S_W;
                end
            end
            S_FIN: begin
                n_result = anc_val;
                n_done   = 1'b1;
                n_state  = S_IDLE;
            end
            S_LR: begin
                if (dist_sh[0]) begin
                    anc_raddr = anc_addr(r_ubase, r_lvl);
                    n_ard_ok  = node_ok(r_u);
                    n_state   = S_LQ;
                end else if (r_lvl == '0) begin
                    n_result = r_u;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_lvl = next_lvl;
                end
            end
            S_LQ: begin
                n_u     = anc_val;
                n_ubase = anc_base(anc_val);
                if (r_lvl == '0) begin
                    n_result = anc_val;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_lvl   = next_lvl;
                    n_state = S_LR;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_done      <= 1'b0;
            r_max_level <= CFG_W'(MAX_LEVEL_RST);
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (i_cfg_valid) begin
                r_max_level <= i_cfg_data;
            end
        end
        r_result <= n_result;
        r_a      <= n_a;
        r_b      <= n_b;
        r_u      <= n_u;
        r_ubase  <= n_ubase;
        r_w      <= n_w;
        r_wbase  <= n_wbase;
        r_lvl    <= n_lvl;
        r_dist   <= n_dist;
        r_tu     <= n_tu;
        r_tv     <= n_tv;
        r_ard_ok <= n_ard_ok;
        r_trd_ok <= n_trd_ok;
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_result_node = r_result;
    assign o_cfg_ready   = 1'b1;

endmodule

`default_nettype wire

@@ hw/rtl/taqe_ram.sv @@
// ----------------------------------------------------------------------------
// taqe_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module taqe_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/taqe_cmp.sv @@
// ----------------------------------------------------------------------------
// taqe_cmp - interval ancestor test
// High when the first node's DFS interval encloses the second node's.
// ----------------------------------------------------------------------------
`default_nettype none

module taqe_cmp
    import taqe_pkg::*;
(
    input  wire t_times i_anc,
    input  wire t_times i_des,
    output logic        o_covers
);

    assign o_covers = (i_anc.t_entry <= i_des.t_entry) && (i_anc.t_exit >= i_des.t_exit);

endmodule

`default_nettype wire

@@ hw/rtl/taqe_checker.sv @@
// ----------------------------------------------------------------------------
// taqe_checker - port-level checks of the ancestor query engine
// Command/result sequencing as seen on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module taqe_checker
    import taqe_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_start,
    input wire logic       o_busy,
    input wire logic [1:0] i_op,
    input wire logic       o_done
);

    logic take_wr, take_q;

    assign take_wr = i_start && !o_busy &&
                     ((t_op'(i_op) == OP_WR_ANC) || (t_op'(i_op) == OP_WR_TIME));
    assign take_q  = i_start && !o_busy &&
                     ((t_op'(i_op) == OP_LCA) || (t_op'(i_op) == OP_LIFT));

    // table writes complete at once and yield no result
    a_wr_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_wr |=> (!o_busy && !o_done))
        else $error("write word produced a result or busy");

    // a query always occupies the engine
    a_q_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_q |=> o_busy)
        else $error("query word did not raise busy");

    // results appear only once the engine is free
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobe while busy");

    // every finished query delivers a result
    a_fall_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(o_busy) && $past(i_rst_n)) |-> o_done)
        else $error("busy dropped without a result");

endmodule

bind tree_ancestor_query_engine_unit taqe_checker u_taqe_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .i_op    (i_op),
    .o_done  (o_done)
);

`default_nettype wire

@@ tb/ancestor_answer_monitor.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ancestor_answer_monitor - watches the engine's command, config and result
// Mirrors the lifting table, the DFS times and max_level, works out the
// answer of every accepted query and compares each result word in order.
// ----------------------------------------------------------------------------
module ancestor_answer_monitor
    import taqe_pkg::*;
#(
    parameter int NODES  = 1024,
    parameter int LEVELS = 11
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_busy,
    input  wire logic [1:0]        i_op,
    input  wire logic [NODE_W-1:0] i_node_a,
    input  wire logic [NODE_W-1:0] i_node_b,
    input  wire logic [LVL_FW-1:0] i_level,
    input  wire logic [NODE_W-1:0] i_ancestor_node,
    input  wire logic [TIME_W-1:0] i_entry_time,
    input  wire logic [TIME_W-1:0] i_exit_time,
    input  wire logic [DIST_W-1:0] i_distance,
    input  wire logic              i_done,
    input  wire logic [NODE_W-1:0] i_result_node,
    input  wire logic              i_cfg_valid,
    input  wire logic              i_cfg_ready,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    output int                     o_mismatches,
    output int                     o_pending
);

    typedef logic [NODE_W-1:0] t_node;

    typedef struct packed {
        t_op               op;
        t_node             a;
        t_node             b;
        logic [DIST_W-1:0] steps;
        t_node             node;
    } t_answer;

    t_node             hop   [NODES][LEVELS];
    logic [TIME_W-1:0] t_in  [NODES];
    logic [TIME_W-1:0] t_out [NODES];
    logic [CFG_W-1:0]  level_cap = CFG_W'(MAX_LEVEL_RST);

    t_answer answers_due [$];
    t_answer oldest;
    t_answer fresh;
    int      miss_cnt = 0;

    // u is an ancestor of v (or v itself)
    function automatic bit spans(t_node u, t_node v);
        return (t_in[u] <= t_in[v]) && (t_out[u] >= t_out[v]);
    endfunction

    // max_level saturates at the top table level
    function automatic int top_rung();
        int cap;
        cap = int'(level_cap);
        if (cap > LEVELS - 1)
            cap = LEVELS - 1;
        return cap;
    endfunction

    function automatic t_node meet(t_node u, t_node v);
        t_node w;
        int    r;
        if (spans(u, v))
            return u;
        if (spans(v, u))
            return v;
        for (r = top_rung(); r >= 0; r--) begin
            w = hop[u][r];
            if (!spans(w, v))
                u = w;
        end
        return hop[u][0];
    endfunction

    // distance bits above the top level drop out
    function automatic t_node climb(t_node u, logic [DIST_W-1:0] steps);
        int r;
        for (r = top_rung(); r >= 0; r--) begin
            if (((steps >> r) & 1'b1) != 0)
                u = hop[u][r];
        end
        return u;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            level_cap = CFG_W'(MAX_LEVEL_RST);
            answers_due.delete();
        end else begin
            // result first: a word retiring now belongs to an older query
            if (i_done) begin
                if (answers_due.size() == 0) begin
                    miss_cnt++;
                    if (miss_cnt <= 10)
                        $display("%0t: result node %0d with no query waiting",
                                 $time, i_result_node);
                end else begin
                    oldest = answers_due.pop_front();
                    if (i_result_node !== oldest.node) begin
                        miss_cnt++;
                        if (miss_cnt <= 10)
                            $display("%0t: %s a=%0d b=%0d steps=%0d: expected %0d, got %0d",
                                     $time,
                                     (oldest.op == OP_LCA) ? "common ancestor" : "lift",
                                     oldest.a, oldest.b, oldest.steps, oldest.node,
                                     i_result_node);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                level_cap = i_cfg_data;
            if (i_start && !i_busy) begin
                case (t_op'(i_op))
                    OP_WR_ANC: begin
                        if (i_node_a < NODES && i_level < LEVELS)
                            hop[i_node_a][i_level] = i_ancestor_node;
                    end
                    OP_WR_TIME: begin
                        if (i_node_a < NODES) begin
                            t_in[i_node_a]  = i_entry_time;
                            t_out[i_node_a] = i_exit_time;
                        end
                    end
                    default: begin
                        fresh.op    = t_op'(i_op);
                        fresh.a     = i_node_a;
                        fresh.b     = i_node_b;
                        fresh.steps = i_distance;
                        fresh.node  = (t_op'(i_op) == OP_LCA) ? meet(i_node_a, i_node_b)
                                                              : climb(i_node_a, i_distance);
                        answers_due = {answers_due, fresh};
                    end
                endcase
            end
        end
        o_mismatches <= miss_cnt;
        o_pending    <= answers_due.size();
    end

endmodule

@@ tb/tb_tree_ancestor_query_engine_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tree_ancestor_query_engine_unit - common ancestor / lift engine bench
// Loads small random trees (lifting table plus DFS times), then fires mixed
// common-ancestor and ancestor-at-distance queries under several max_level
// settings. A side monitor predicts and checks every result word.
// ----------------------------------------------------------------------------
module tb_tree_ancestor_query_engine_unit;
    import taqe_pkg::*;

    localparam int NODES    = 1024;
    localparam int LEVELS   = 11;
    localparam int MAX_TREE = 32;   // tree array bound (random trees hold up to 26 nodes)
    localparam int PHASES   = 6;    // random trees, one max_level each
    localparam int SETTLE   = 40;   // wait after a drain, longer than the longest query

    logic              i_clk;
    logic              i_rst_n         = 1'b0;
    logic              i_start         = 1'b0;
    logic              o_busy;
    logic [1:0]        i_op            = '0;
    logic [NODE_W-1:0] i_node_a        = '0;
    logic [NODE_W-1:0] i_node_b        = '0;
    logic [LVL_FW-1:0] i_level         = '0;
    logic [NODE_W-1:0] i_ancestor_node = '0;
    logic [TIME_W-1:0] i_entry_time    = '0;
    logic [TIME_W-1:0] i_exit_time     = '0;
    logic [DIST_W-1:0] i_distance      = '0;
    logic              o_done;
    logic [NODE_W-1:0] o_result_node;
    logic              i_cfg_valid     = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_W-1:0]  i_cfg_data      = '0;

    int miss_total;
    int due_total;
    bit calm = 1'b0;    // no sender gaps in the closing phase

    // scratch tree: index 0 is the root, parents always precede children
    int                tree_size;
    int                tree_id     [MAX_TREE];
    int                parent_of   [MAX_TREE];
    int                depth_of    [MAX_TREE];
    int                hop_idx     [LEVELS][MAX_TREE];
    int                enter_tick  [MAX_TREE];
    int                leave_tick  [MAX_TREE];
    int                tick;
    bit                taken       [NODES];

    tree_ancestor_query_engine_unit #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_op            (i_op),
        .i_node_a        (i_node_a),
        .i_node_b        (i_node_b),
        .i_level         (i_level),
        .i_ancestor_node (i_ancestor_node),
        .i_entry_time    (i_entry_time),
        .i_exit_time     (i_exit_time),
        .i_distance      (i_distance),
        .o_done          (o_done),
        .o_result_node   (o_result_node),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    ancestor_answer_monitor #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) answers (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_busy          (o_busy),
        .i_op            (i_op),
        .i_node_a        (i_node_a),
        .i_node_b        (i_node_b),
        .i_level         (i_level),
        .i_ancestor_node (i_ancestor_node),
        .i_entry_time    (i_entry_time),
        .i_exit_time     (i_exit_time),
        .i_distance      (i_distance),
        .i_done          (o_done),
        .i_result_node   (o_result_node),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_mismatches    (miss_total),
        .o_pending       (due_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #5_000_000;
        $display("tb_tree_ancestor_query_engine_unit NOT OK");
        $finish;
    end

    // One command word. Runs at a rising edge, returns at the edge that took
    // it. Reads of o_busy right after the edge see the pre-edge value.
    // Outside the closing phase a random idle gap may come
    // first, so gaps land anywhere in the engine's walk.
    task automatic issue_cmd(input t_op op, input int unsigned a,
                             input int unsigned b, input int unsigned lvl,
                             input int unsigned anc, input int unsigned tin,
                             input int unsigned tout, input int unsigned steps);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start         <= 1'b1;
        i_op            <= op;
        i_node_a        <= a[NODE_W-1:0];
        i_node_b        <= b[NODE_W-1:0];
        i_level         <= lvl[LVL_FW-1:0];
        i_ancestor_node <= anc[NODE_W-1:0];
        i_entry_time    <= tin[TIME_W-1:0];
        i_exit_time     <= tout[TIME_W-1:0];
        i_distance      <= steps[DIST_W-1:0];
        do @(posedge i_clk); while (o_busy);
    endtask

    // max_level write; only called with the engine idle
    task automatic write_cap(input int unsigned cap);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap[CFG_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // drain: every query answered, then let a trailing write settle too
    task automatic wait_quiet();
        i_start <= 1'b0;
        do @(posedge i_clk); while (due_total != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // preorder numbering: entry tick on the way down, exit tick on the way up
    function automatic void number_dfs(int i);
        int j;
        enter_tick[i] = tick;
        tick = tick + 1;
        for (j = i + 1; j < tree_size; j++) begin
            if (parent_of[j] == i)
                number_dfs(j);
        end
        leave_tick[i] = tick;
        tick = tick + 1;
    endfunction

    initial begin
        int                ph;
        int                i;
        int                k;
        int                q;
        int                x;
        int                y;
        int                spread;
        int                step;
        int                lim;
        int                n_queries;
        int                pick;
        int                phase_cap [PHASES];
        int                stamp     [2*MAX_TREE];
        int                stray;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---------------------------------------------------------------
        // Directed: max_level 0, so only level 0 of the table is ever read.
        // Tree: 0 root [0,2047]; 1023 under 0; 341 under 1023; 682 under 0.
        // ---------------------------------------------------------------
        write_cap(0);
        issue_cmd(OP_WR_TIME, 0,    $urandom, $urandom, $urandom, 0,    2047, $urandom);
        issue_cmd(OP_WR_TIME, 1023, $urandom, $urandom, $urandom, 1,    1000, $urandom);
        issue_cmd(OP_WR_TIME, 341,  $urandom, $urandom, $urandom, 2,    999,  $urandom);
        issue_cmd(OP_WR_TIME, 682,  $urandom, $urandom, $urandom, 1001, 2046, $urandom);
        issue_cmd(OP_WR_ANC, 0,    1023,     0, 0,    $urandom, $urandom, $urandom);
        issue_cmd(OP_WR_ANC, 1023, 0,        0, 0,    $urandom, $urandom, $urandom);
        issue_cmd(OP_WR_ANC, 341,  $urandom, 0, 1023, $urandom, $urandom, $urandom);
        issue_cmd(OP_WR_ANC, 682,  $urandom, 0, 0,    $urandom, $urandom, $urandom);
        // levels past the table are dropped
        issue_cmd(OP_WR_ANC, 341,  $urandom, 15, 682,  $urandom, $urandom, $urandom);
        issue_cmd(OP_WR_ANC, 1023, $urandom, 11, 1023, $urandom, $urandom, $urandom);
        // common ancestor: disjoint, ancestor either way round, same node
        issue_cmd(OP_LCA, 1023, 682,  $urandom, $urandom, $urandom, $urandom, $urandom);
        issue_cmd(OP_LCA, 341,  682,  $urandom, $urandom, $urandom, $urandom, $urandom);
        issue_cmd(OP_LCA, 0,    1023, $urandom, $urandom, $urandom, $urandom, $urandom);
        issue_cmd(OP_LCA, 341,  1023, $urandom, $urandom, $urandom, $urandom, $urandom);
        issue_cmd(OP_LCA, 682,  682,  $urandom, $urandom, $urandom, $urandom, $urandom);
        issue_cmd(OP_LCA, 1023, 341,  $urandom, $urandom, $urandom, $urandom, $urandom);
        // lift: zero distance, one step, high bits ignored, root holds
        issue_cmd(OP_LIFT, 341, $urandom, $urandom, $urandom, $urandom, $urandom, 0);
        issue_cmd(OP_LIFT, 341, $urandom, $urandom, $urandom, $urandom, $urandom, 1);
        issue_cmd(OP_LIFT, 341, $urandom, $urandom, $urandom, $urandom, $urandom, 1023);
        issue_cmd(OP_LIFT, 341, $urandom, $urandom, $urandom, $urandom, $urandom, 2);
        issue_cmd(OP_LIFT, 0,   $urandom, $urandom, $urandom, $urandom, $urandom, 1);
        wait_quiet();

        // ---------------------------------------------------------------
        // Random trees. max_level: 15 (saturates), 10, 0, then one mid value,
        // one above the table and one anything.
        // ---------------------------------------------------------------
        phase_cap[0] = 15;
        phase_cap[1] = MAX_LEVEL_RST;
        phase_cap[2] = 0;
        phase_cap[3] = $urandom_range(1, 9);
        phase_cap[4] = $urandom_range(LEVELS, 14);
        phase_cap[5] = $urandom_range(0, 15);

        for (ph = 0; ph < PHASES; ph++) begin
            calm = (ph == PHASES - 1);
            write_cap(phase_cap[ph]);

            // shape: spread 0 gives a chain, larger spread a bushier tree
            tree_size = $urandom_range(6, 26);
            spread    = $urandom_range(0, tree_size);
            for (x = 0; x < NODES; x++)
                taken[x] = 1'b0;
            for (i = 0; i < tree_size; i++) begin
                do pick = $urandom_range(0, NODES - 1); while (taken[pick]);
                taken[pick] = 1'b1;
                tree_id[i]  = pick;
                if (i == 0) begin
                    parent_of[i] = 0;   // root is its own parent
                    depth_of[i]  = 0;
                end else begin
                    lim          = (spread < i - 1) ? spread : i - 1;
                    parent_of[i] = i - 1 - int'($urandom_range(0, lim));
                    depth_of[i]  = depth_of[parent_of[i]] + 1;
                end
            end
            for (i = 0; i < tree_size; i++)
                hop_idx[0][i] = parent_of[i];
            for (k = 1; k < LEVELS; k++)
                for (i = 0; i < tree_size; i++)
                    hop_idx[k][i] = hop_idx[k-1][hop_idx[k-1][i]];
            tick = 0;
            number_dfs(0);
            // spread the ticks over the whole time range, order kept
            step = 2048 / (2 * tree_size);
            for (x = 0; x < 2 * tree_size; x++)
                stamp[x] = x * step + int'($urandom_range(0, step - 1));

            // load every level and the times of every tree node; now and
            // then a stray write that no query of this tree can see
            for (i = 0; i < tree_size; i++) begin
                issue_cmd(OP_WR_TIME, tree_id[i], $urandom, $urandom, $urandom,
                          stamp[enter_tick[i]], stamp[leave_tick[i]], $urandom);
                for (k = 0; k < LEVELS; k++) begin
                    if ($urandom_range(0, 11) == 0) begin
                        if ($urandom_range(0, 1) == 1) begin
                            issue_cmd(OP_WR_ANC, tree_id[$urandom_range(0, tree_size - 1)],
                                      $urandom, $urandom_range(LEVELS, 15), $urandom,
                                      $urandom, $urandom, $urandom);
                        end else begin
                            do stray = $urandom_range(0, NODES - 1); while (taken[stray]);
                            issue_cmd(t_op'($urandom_range(0, 1)), stray, $urandom,
                                      $urandom_range(0, 15), $urandom, $urandom,
                                      $urandom, $urandom);
                        end
                    end
                    issue_cmd(OP_WR_ANC, tree_id[i], $urandom, k, tree_id[hop_idx[k][i]],
                              $urandom, $urandom, $urandom);
                end
            end

            // queries; lift distances mostly near the node's depth
            n_queries = $urandom_range(60, 90);
            for (q = 0; q < n_queries; q++) begin
                x = $urandom_range(0, tree_size - 1);
                y = $urandom_range(0, tree_size - 1);
                if ($urandom_range(0, 1) == 1)
                    issue_cmd(OP_LCA, tree_id[x], tree_id[y], $urandom, $urandom,
                              $urandom, $urandom, $urandom);
                else
                    issue_cmd(OP_LIFT, tree_id[x], $urandom, $urandom, $urandom,
                              $urandom, $urandom,
                              ($urandom_range(0, 2) == 0) ? $urandom
                                                          : $urandom_range(0, depth_of[x] + 2));
            end
            wait_quiet();
        end

        if (miss_total == 0 && due_total == 0)
            $display("tb_tree_ancestor_query_engine_unit OK");
        else
            $display("tb_tree_ancestor_query_engine_unit NOT OK");
        $finish;
    end

endmodule
